// ===== sv/swbs_pkg.sv =====
`timescale 1ns / 1ps

package swbs_pkg;

	// Default window span, one cell per position.
	localparam int WINDOW_BITS_DEF = 256;

	// Width of the reported member count.
	localparam int COUNT_W = 9;

	// Operation codes carried by a request.
	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	// What the presence bits of every cell do in one cycle.
	typedef enum logic [1:0] {
		PO_HOLD,
		PO_UP,
		PO_DOWN,
		PO_CLEAR
	} pres_op_t;

	// Broadcast control from the sequencer to the row of cells.
	typedef struct packed {
		pres_op_t pres_op;
		logic     scan_load;
		logic     scan_shift;
		logic     wr_en;
		logic     wr_val;
	} cell_ctl_t;

endpackage

// ===== sv/swbs_cell.sv =====
`timescale 1ns / 1ps

module swbs_cell #(
	parameter int OFF_W = 8,
	parameter int INDEX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swbs_pkg::cell_ctl_t ctl,
	input  logic [OFF_W-1:0]    wr_off,
	input  logic                pres_lo,
	input  logic                pres_hi,
	input  logic                scan_hi,
	output logic                pres,
	output logic                scan
);

	localparam logic [OFF_W-1:0] MY_OFF = OFF_W'(INDEX);

	logic pres_q;
	logic scan_q;

	// Presence bit: shifts with its neighbours, clears, or takes a write aimed at this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pres_q <= 1'b0;
		end else begin
			case (ctl.pres_op)
				swbs_pkg::PO_UP: begin
					pres_q <= pres_lo;
				end
				swbs_pkg::PO_DOWN: begin
					pres_q <= pres_hi;
				end
				swbs_pkg::PO_CLEAR: begin
					pres_q <= 1'b0;
				end
				default: begin
					if (ctl.wr_en && (wr_off == MY_OFF)) begin
						pres_q <= ctl.wr_val;
					end
				end
			endcase
		end
	end

	// Scan copy: loaded from the presence bit, then walked down towards cell zero.
	always_ff @(posedge clk) begin
		if (ctl.scan_load) begin
			scan_q <= pres_q;
		end else if (ctl.scan_shift) begin
			scan_q <= scan_hi;
		end
	end

	assign pres = pres_q;
	assign scan = scan_q;

endmodule

// ===== sv/sliding_window_bitmap_set_top.sv =====
`timescale 1ns / 1ps

// Channel   | Handshake           | Payload
// ----------+---------------------+-------------------------------------------------------
// request   | start in, busy out  | mode, element
// result    | done out (1 cycle)  | accepted, overflow, member_count, set_empty,
//           |                     | lowest, highest
//
// A request is taken when start is high and busy is low; one result follows per request.
// Lookups walk a scan copy of the window down to cell zero, one position per cycle; a bit is
// then written when the request changes the set. A new minimum shifts the row up by its
// distance. Removing the minimum shifts the row down to the next element.
// The asynchronous reset clears every presence bit at once.
// The result is shown for one cycle with done and cannot be held off by the receiver.

module sliding_window_bitmap_set_top #(
	parameter int WINDOW_BITS = swbs_pkg::WINDOW_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [1:0]                         mode,
	input  logic signed [31:0]                 element,
	output logic                               done,
	output logic                               accepted,
	output logic                               overflow,
	output logic [swbs_pkg::COUNT_W-1:0]       member_count,
	output logic                               set_empty,
	output logic signed [31:0]                 lowest,
	output logic signed [31:0]                 highest
);

	localparam int OFF_W = $clog2(WINDOW_BITS);
	localparam logic [32:0] WIN_MAX = 33'(WINDOW_BITS - 1);

	typedef enum logic [6:0] {
		S_IDLE       = 7'b0000001,
		S_DECIDE     = 7'b0000010,
		S_SCAN       = 7'b0000100,
		S_SHIFT_UP   = 7'b0001000,
		S_SHIFT_DOWN = 7'b0010000,
		S_WRITE      = 7'b0100000,
		S_CLEAR      = 7'b1000000
	} fsm_t;

	fsm_t                          st_q;
	logic [1:0]                    mode_q;
	logic signed [31:0]            elem_q;
	logic signed [31:0]            base_q;
	logic signed [31:0]            top_q;
	logic [swbs_pkg::COUNT_W-1:0]  pop_q;
	logic                          empty_q;
	logic [OFF_W-1:0]              off_q;
	logic [OFF_W-1:0]              cnt_q;
	logic [OFF_W-1:0]              last_q;
	logic                          wr_val_q;
	logic                          rm_top_q;
	logic                          done_q;
	logic                          acc_q;
	logic                          ovf_q;

	swbs_pkg::cell_ctl_t           ctl;
	logic [WINDOW_BITS-1:0]        pres_w;
	logic [WINDOW_BITS-1:0]        scan_w;

	logic [33:0]                   elem_x;
	logic [33:0]                   base_x;
	logic [33:0]                   top_x;
	logic [33:0]                   off_full;
	logic [33:0]                   span_lo;
	logic [33:0]                   shift_amt;
	logic                          below;
	logic                          in_win;
	logic                          too_far;
	logic                          e_eq_top;
	logic                          e_gt_top;
	logic signed [31:0]            top_from_last;

	// Row of cells, each holding one window position.
	for (genvar i = 0; i < WINDOW_BITS; i++) begin : g_cell
		logic lo_n;
		logic hi_n;
		logic scan_hi_n;

		if (i == 0) begin : g_first
			assign lo_n = 1'b0;
		end else begin : g_lo
			assign lo_n = pres_w[i-1];
		end

		if (i == WINDOW_BITS - 1) begin : g_last
			assign hi_n      = 1'b0;
			assign scan_hi_n = 1'b0;
		end else begin : g_hi
			assign hi_n      = pres_w[i+1];
			assign scan_hi_n = scan_w[i+1];
		end

		swbs_cell #(
			.OFF_W (OFF_W),
			.INDEX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.wr_off  (off_q),
			.pres_lo (lo_n),
			.pres_hi (hi_n),
			.scan_hi (scan_hi_n),
			.pres    (pres_w[i]),
			.scan    (scan_w[i])
		);
	end

	// Window arithmetic on the held request, sign-extended to keep every difference exact.
	always_comb begin
		elem_x        = {{2{elem_q[31]}}, elem_q};
		base_x        = {{2{base_q[31]}}, base_q};
		top_x         = {{2{top_q[31]}}, top_q};
		off_full      = elem_x - base_x;
		span_lo       = top_x - elem_x;
		shift_amt     = base_x - elem_x;
		below         = off_full[33];
		in_win        = !off_full[33] && (off_full[32:0] <= WIN_MAX);
		too_far       = span_lo[32:0] > WIN_MAX;
		e_eq_top      = (elem_q == top_q);
		e_gt_top      = (elem_q > top_q);
		top_from_last = base_q + $signed({{(32-OFF_W){1'b0}}, last_q});
	end

	// Broadcast control to the cells for the current step.
	always_comb begin
		ctl            = '0;
		ctl.pres_op    = swbs_pkg::PO_HOLD;
		case (st_q)
			S_IDLE: begin
				ctl.scan_load = start;
			end
			S_SCAN: begin
				ctl.scan_shift = (cnt_q != off_q);
			end
			S_SHIFT_UP: begin
				ctl.pres_op = swbs_pkg::PO_UP;
			end
			S_SHIFT_DOWN: begin
				ctl.pres_op = swbs_pkg::PO_DOWN;
			end
			S_CLEAR: begin
				ctl.pres_op = swbs_pkg::PO_CLEAR;
			end
			S_WRITE: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_val = wr_val_q;
			end
			default: begin
				ctl.pres_op = swbs_pkg::PO_HOLD;
			end
		endcase
	end

	// Sequencer and set summary registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			mode_q   <= swbs_pkg::MODE_ADD;
			elem_q   <= '0;
			base_q   <= '0;
			top_q    <= '0;
			pop_q    <= '0;
			empty_q  <= 1'b1;
			off_q    <= '0;
			cnt_q    <= '0;
			last_q   <= '0;
			wr_val_q <= 1'b0;
			rm_top_q <= 1'b0;
			done_q   <= 1'b0;
			acc_q    <= 1'b0;
			ovf_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				S_IDLE: begin
					if (start) begin
						mode_q <= mode;
						elem_q <= element;
						cnt_q  <= '0;
						last_q <= '0;
						st_q   <= S_DECIDE;
					end
				end

				S_DECIDE: begin
					case (mode_q)
						swbs_pkg::MODE_ADD: begin
							if (empty_q) begin
								base_q   <= elem_q;
								top_q    <= elem_q;
								pop_q    <= swbs_pkg::COUNT_W'(1);
								empty_q  <= 1'b0;
								off_q    <= '0;
								wr_val_q <= 1'b1;
								st_q     <= S_WRITE;
							end else if (below) begin
								if (too_far) begin
									done_q <= 1'b1;
									acc_q  <= 1'b0;
									ovf_q  <= 1'b1;
									st_q   <= S_IDLE;
								end else begin
									cnt_q  <= shift_amt[OFF_W-1:0];
									base_q <= elem_q;
									pop_q  <= pop_q + swbs_pkg::COUNT_W'(1);
									st_q   <= S_SHIFT_UP;
								end
							end else if (in_win) begin
								off_q    <= off_full[OFF_W-1:0];
								rm_top_q <= 1'b0;
								st_q     <= S_SCAN;
							end else begin
								done_q <= 1'b1;
								acc_q  <= 1'b0;
								ovf_q  <= 1'b1;
								st_q   <= S_IDLE;
							end
						end
						swbs_pkg::MODE_REMOVE: begin
							if (empty_q || !in_win) begin
								done_q <= 1'b1;
								acc_q  <= 1'b0;
								ovf_q  <= 1'b0;
								st_q   <= S_IDLE;
							end else if (off_full[OFF_W-1:0] == '0) begin
								if (pop_q <= swbs_pkg::COUNT_W'(1)) begin
									st_q <= S_CLEAR;
								end else begin
									st_q <= S_SHIFT_DOWN;
								end
							end else begin
								off_q    <= off_full[OFF_W-1:0];
								rm_top_q <= e_eq_top;
								st_q     <= S_SCAN;
							end
						end
						swbs_pkg::MODE_SEARCH: begin
							if (empty_q || !in_win) begin
								done_q <= 1'b1;
								acc_q  <= 1'b0;
								ovf_q  <= 1'b0;
								st_q   <= S_IDLE;
							end else begin
								off_q    <= off_full[OFF_W-1:0];
								rm_top_q <= 1'b0;
								st_q     <= S_SCAN;
							end
						end
						default: begin
							done_q <= 1'b1;
							acc_q  <= 1'b0;
							ovf_q  <= 1'b0;
							st_q   <= S_IDLE;
						end
					endcase
				end

				// Walk the scan copy down; cell zero shows the position cnt_q.
				S_SCAN: begin
					if (cnt_q == off_q) begin
						case (mode_q)
							swbs_pkg::MODE_ADD: begin
								if (scan_w[0]) begin
									done_q <= 1'b1;
									acc_q  <= 1'b0;
									ovf_q  <= 1'b0;
									st_q   <= S_IDLE;
								end else begin
									if (e_gt_top) begin
										top_q <= elem_q;
									end
									pop_q    <= pop_q + swbs_pkg::COUNT_W'(1);
									wr_val_q <= 1'b1;
									st_q     <= S_WRITE;
								end
							end
							swbs_pkg::MODE_REMOVE: begin
								if (rm_top_q) begin
									top_q    <= top_from_last;
									pop_q    <= pop_q - swbs_pkg::COUNT_W'(1);
									wr_val_q <= 1'b0;
									st_q     <= S_WRITE;
								end else if (scan_w[0]) begin
									pop_q    <= pop_q - swbs_pkg::COUNT_W'(1);
									wr_val_q <= 1'b0;
									st_q     <= S_WRITE;
								end else begin
									done_q <= 1'b1;
									acc_q  <= 1'b0;
									ovf_q  <= 1'b0;
									st_q   <= S_IDLE;
								end
							end
							default: begin
								done_q <= 1'b1;
								acc_q  <= scan_w[0];
								ovf_q  <= 1'b0;
								st_q   <= S_IDLE;
							end
						endcase
					end else begin
						// Remember the highest occupied position seen below the target.
						if (scan_w[0]) begin
							last_q <= cnt_q;
						end
						cnt_q <= cnt_q + OFF_W'(1);
					end
				end

				// Row shifts up once per cycle; the new minimum lands in cell zero afterwards.
				S_SHIFT_UP: begin
					cnt_q <= cnt_q - OFF_W'(1);
					if (cnt_q == OFF_W'(1)) begin
						off_q    <= '0;
						wr_val_q <= 1'b1;
						st_q     <= S_WRITE;
					end
				end

				// Row shifts down until the next element reaches cell zero.
				S_SHIFT_DOWN: begin
					base_q <= base_q + 32'sd1;
					if (pres_w[1]) begin
						pop_q  <= pop_q - swbs_pkg::COUNT_W'(1);
						done_q <= 1'b1;
						acc_q  <= 1'b1;
						ovf_q  <= 1'b0;
						st_q   <= S_IDLE;
					end
				end

				S_CLEAR: begin
					base_q  <= '0;
					top_q   <= '0;
					pop_q   <= '0;
					empty_q <= 1'b1;
					done_q  <= 1'b1;
					acc_q   <= 1'b1;
					ovf_q   <= 1'b0;
					st_q    <= S_IDLE;
				end

				S_WRITE: begin
					done_q <= 1'b1;
					acc_q  <= 1'b1;
					ovf_q  <= 1'b0;
					st_q   <= S_IDLE;
				end

				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Result ports show the summary as it stands once the request has finished.
	assign busy         = (st_q != S_IDLE);
	assign done         = done_q;
	assign accepted     = acc_q;
	assign overflow     = ovf_q;
	assign member_count = pop_q;
	assign set_empty    = empty_q;
	assign lowest       = base_q;
	assign highest      = top_q;

endmodule

// ===== sv/swbs_checker.sv =====
`timescale 1ns / 1ps

module swbs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         done,
	input logic                         accepted,
	input logic                         overflow,
	input logic [swbs_pkg::COUNT_W-1:0] member_count,
	input logic                         set_empty,
	input logic signed [31:0]           lowest,
	input logic signed [31:0]           highest
);

	// A taken request keeps the block busy and produces no result in the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy && !done))
		else $error("request taken but block not busy");

	// A result is only shown once the block has become free again.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// A rejected add never counts as accepted.
	a_ovf_rej: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> !accepted)
		else $error("overflow together with accepted");

	// An empty set reports zero count and zero bounds.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && set_empty) |-> ((member_count == '0) && (lowest == '0) && (highest == '0)))
		else $error("empty set with non-zero summary");

	// The minimum never lies above the maximum.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !set_empty) |-> (lowest <= highest))
		else $error("minimum above maximum");

endmodule

bind sliding_window_bitmap_set_top swbs_checker u_swbs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.accepted     (accepted),
	.overflow     (overflow),
	.member_count (member_count),
	.set_empty    (set_empty),
	.lowest       (lowest),
	.highest      (highest)
);

// ===== bench/sliding_window_bitmap_set_checker.sv =====
`timescale 1ns / 1ps

module sliding_window_bitmap_set_checker #(
	parameter int WINDOW_BITS = swbs_pkg::WINDOW_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [1:0]                   mode,
	input  logic signed [31:0]           element,
	input  logic                         done,
	input  logic                         accepted,
	input  logic                         overflow,
	input  logic [swbs_pkg::COUNT_W-1:0] member_count,
	input  logic                         set_empty,
	input  logic signed [31:0]           lowest,
	input  logic signed [31:0]           highest,
	output int                           mismatches,
	output int                           outstanding
);

	import swbs_pkg::*;

	// One result as the block should report it.
	typedef struct packed {
		logic                  hit;
		logic                  ovf;
		logic [COUNT_W-1:0]    count;
		logic                  none_held;
		logic signed [31:0]    least;
		logic signed [31:0]    greatest;
	} set_report_t;

	// Own copy of the set: presence window, bounds, population.
	bit [WINDOW_BITS-1:0] held_bits;
	longint               base_val;
	longint               top_val;
	int unsigned          population;
	bit                   set_is_void;

	set_report_t awaited_reports[$];
	int          bad_reports;

	assign mismatches  = bad_reports;
	assign outstanding = awaited_reports.size();

	// Returns the set to its state after reset.
	function automatic void clear_window();
		held_bits   = '0;
		base_val    = 0;
		top_val     = 0;
		population  = 0;
		set_is_void = 1'b1;
	endfunction

	// Applies one request to the set and returns the report it should give.
	function automatic set_report_t apply_set_request(logic [1:0] op, logic signed [31:0] value);
		longint      e;
		longint      off;
		longint      span;
		longint      step;
		longint      idx;
		bit          hit;
		bit          ovf;
		set_report_t r;
		e   = longint'(value);
		hit = 1'b0;
		ovf = 1'b0;
		case (op)
			MODE_ADD: begin
				if (set_is_void) begin
					// The first element becomes both bounds.
					held_bits    = '0;
					held_bits[0] = 1'b1;
					base_val     = e;
					top_val      = e;
					population   = 1;
					set_is_void  = 1'b0;
					hit          = 1'b1;
				end else if (e < base_val) begin
					// A new minimum moves the window up unless the maximum would drop out.
					if (top_val - e > WINDOW_BITS - 1) begin
						ovf = 1'b1;
					end else begin
						held_bits    = held_bits << (base_val - e);
						held_bits[0] = 1'b1;
						base_val     = e;
						population++;
						hit          = 1'b1;
					end
				end else begin
					off = e - base_val;
					if (off > WINDOW_BITS - 1) begin
						ovf = 1'b1;
					end else if (!held_bits[off]) begin
						held_bits[off] = 1'b1;
						if (e > top_val)
							top_val = e;
						population++;
						hit = 1'b1;
					end
				end
			end
			MODE_REMOVE: begin
				if (!set_is_void && e >= base_val && e - base_val <= WINDOW_BITS - 1) begin
					off = e - base_val;
					if (off == 0) begin
						if (population <= 1) begin
							clear_window();
						end else begin
							// Slide down to the next held position, at most up to the maximum.
							span = top_val - base_val;
							if (span > WINDOW_BITS - 1)
								span = WINDOW_BITS - 1;
							step = 1;
							while (step < span && !held_bits[step])
								step++;
							held_bits = held_bits >> step;
							base_val  = base_val + step;
							population--;
						end
						hit = 1'b1;
					end else if (e == top_val) begin
						// Removing the maximum looks downward for the next one.
						idx = off - 1;
						while (idx >= 0 && !held_bits[idx])
							idx--;
						if (idx >= 0) begin
							held_bits[off] = 1'b0;
							top_val        = base_val + idx;
							population--;
							hit            = 1'b1;
						end
					end else if (held_bits[off]) begin
						held_bits[off] = 1'b0;
						population--;
						hit            = 1'b1;
					end
				end
			end
			MODE_SEARCH: begin
				if (!set_is_void && e >= base_val && e - base_val <= WINDOW_BITS - 1)
					hit = held_bits[e - base_val];
			end
			default: begin
				// The spare operation code leaves the set alone.
			end
		endcase
		r.hit       = hit;
		r.ovf       = ovf;
		r.count     = population[COUNT_W-1:0];
		r.none_held = set_is_void;
		r.least     = set_is_void ? 32'sd0 : base_val[31:0];
		r.greatest  = set_is_void ? 32'sd0 : top_val[31:0];
		return r;
	endfunction

	// Compares results against the oldest prediction and predicts each new request.
	always @(posedge clk or negedge arst_n) begin
		set_report_t want;
		set_report_t got;
		if (!arst_n) begin
			clear_window();
			awaited_reports.delete();
			bad_reports = 0;
		end else begin
			if (done) begin
				got = '{accepted, overflow, member_count, set_empty, lowest, highest};
				if (awaited_reports.size() == 0) begin
					if (bad_reports < 10)
						$display("%0t: result with no request pending: acc %0b ovf %0b cnt %0d",
							$realtime, accepted, overflow, member_count);
					bad_reports++;
				end else begin
					want = awaited_reports.pop_front();
					if (got !== want) begin
						if (bad_reports < 10) begin
							$display("%0t: result mismatch", $realtime);
							$display("  expected acc %0b ovf %0b cnt %0d empty %0b low %0d high %0d",
								want.hit, want.ovf, want.count, want.none_held,
								want.least, want.greatest);
							$display("  actual   acc %0b ovf %0b cnt %0d empty %0b low %0d high %0d",
								accepted, overflow, member_count, set_empty, lowest, highest);
						end
						bad_reports++;
					end
				end
			end
			if (start && !busy)
				awaited_reports.push_back(apply_set_request(mode, element));
		end
	end

endmodule

// ===== bench/sliding_window_bitmap_set_top_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_bitmap_set_top_tb;

	import swbs_pkg::*;

	localparam int         WINDOW_BITS    = WINDOW_BITS_DEF;
	localparam logic [1:0] MODE_SPARE     = 2'd3;
	localparam int         RANDOM_ITEMS   = 1950;
	localparam int         WATCHDOG_LIMIT = 3000;
	localparam int         SETTLE_CYCLES  = 300;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            mode;
	logic signed [31:0]    element;
	logic                  done;
	logic                  accepted;
	logic                  overflow;
	logic [COUNT_W-1:0]    member_count;
	logic                  set_empty;
	logic signed [31:0]    lowest;
	logic signed [31:0]    highest;
	int                    mismatches;
	int                    outstanding;

	int unsigned           requests_sent;
	bit                    burst;
	logic signed [31:0]    added_values[$];
	int                    idle_cycles;

	sliding_window_bitmap_set_top #(
		.WINDOW_BITS(WINDOW_BITS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element(element),
		.done(done),
		.accepted(accepted),
		.overflow(overflow),
		.member_count(member_count),
		.set_empty(set_empty),
		.lowest(lowest),
		.highest(highest)
	);

	sliding_window_bitmap_set_checker #(
		.WINDOW_BITS(WINDOW_BITS)
	) set_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.element(element),
		.done(done),
		.accepted(accepted),
		.overflow(overflow),
		.member_count(member_count),
		.set_empty(set_empty),
		.lowest(lowest),
		.highest(highest),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Free-running clock.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Issues one request, after a random pause unless in a burst, and waits until the block takes it.
	task automatic send_request(input logic [1:0] op, input logic signed [31:0] value);
		int unsigned gap;
		gap = burst ? 0 : $urandom_range(0, 10);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start   <= 1'b1;
		mode    <= op;
		element <= value;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
		requests_sent++;
	endtask

	// Picks a value added earlier: any of them, the least or the greatest.
	function automatic logic signed [31:0] added_value_pick();
		int unsigned how;
		int          idx;
		int          pick;
		how  = $urandom_range(0, 2);
		pick = $urandom_range(0, added_values.size() - 1);
		for (idx = 0; idx < added_values.size(); idx++) begin
			if (how == 1 && added_values[idx] < added_values[pick])
				pick = idx;
			if (how == 2 && added_values[idx] > added_values[pick])
				pick = idx;
		end
		return added_values[pick];
	endfunction

	// Pauses the request side until every result has come back.
	task automatic wait_for_results();
		start <= 1'b0;
		do
			@(negedge clk);
		while (outstanding != 0);
	endtask

	// Directed requests, then random phases of related values, then the verdict.
	initial begin
		int unsigned        target;
		int unsigned        fills;
		int unsigned        spread;
		int unsigned        roll;
		int unsigned        stride;
		int unsigned        first;
		int                 k;
		int                 idx;
		int                 phase_len;
		bit                 paused;
		logic signed [31:0] centre;
		logic signed [31:0] value;

		start         = 1'b0;
		mode          = MODE_ADD;
		element       = '0;
		arst_n        = 1'b0;
		requests_sent = 0;
		burst         = 1'b0;
		fills         = 0;
		paused        = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty set, bounds of the window, shifts in both directions and the last removal.
		send_request(MODE_SEARCH, 32'sd5);
		send_request(MODE_REMOVE, 32'sd5);
		send_request(MODE_SPARE, 32'sd5);
		send_request(MODE_ADD, 32'sd100);
		send_request(MODE_ADD, 32'sd100);
		send_request(MODE_ADD, 32'sd355);
		send_request(MODE_ADD, 32'sd356);
		send_request(MODE_ADD, 32'sd99);
		send_request(MODE_ADD, 32'sd150);
		send_request(MODE_SEARCH, 32'sd150);
		send_request(MODE_SEARCH, 32'sd151);
		send_request(MODE_SEARCH, 32'sd99);
		send_request(MODE_SEARCH, 32'sd356);
		send_request(MODE_REMOVE, 32'sd355);
		send_request(MODE_ADD, 32'sd0);
		send_request(MODE_REMOVE, 32'sd0);
		send_request(MODE_REMOVE, 32'sd120);
		send_request(MODE_REMOVE, 32'sd600);
		send_request(MODE_SPARE, 32'sd100);
		send_request(MODE_REMOVE, 32'sd150);
		send_request(MODE_REMOVE, 32'sd100);
		send_request(MODE_ADD, 32'sh7FFFFFFF);
		send_request(MODE_ADD, 32'sh80000000);
		send_request(MODE_ADD, 32'sh7FFFFF00);
		send_request(MODE_SEARCH, 32'sh7FFFFFFF);
		send_request(MODE_REMOVE, 32'sh7FFFFF00);
		send_request(MODE_REMOVE, 32'sh7FFFFFFF);
		send_request(MODE_ADD, 32'sh80000000);
		send_request(MODE_REMOVE, 32'sh80000000);

		target = requests_sent + RANDOM_ITEMS;
		while (requests_sent < target) begin
			burst = ($urandom_range(0, 3) == 0);
			added_values.delete();

			// Once in the middle of the run, let the block drain completely.
			if (!paused && requests_sent + RANDOM_ITEMS / 2 >= target) begin
				wait_for_results();
				paused = 1'b1;
			end

			if (fills < 2 && target - requests_sent > 300 && $urandom_range(0, 5) == 0) begin
				// Fill every position of one window in a scrambled order.
				fills++;
				centre = $urandom_range(0, 32'h7FFFFE00);
				stride = 2 * $urandom_range(0, 127) + 1;
				first  = $urandom_range(0, WINDOW_BITS - 1);
				for (k = 0; k < WINDOW_BITS; k++) begin
					value = centre + ((k * stride + first) % WINDOW_BITS);
					send_request(MODE_ADD, value);
					added_values.push_back(value);
				end
				send_request(MODE_ADD, centre + WINDOW_BITS);
				send_request(MODE_ADD, centre - 1);
			end else begin
				// A run of requests around one centre, mostly inside the window.
				case ($urandom_range(0, 3))
					0: centre = 32'h7FFFFF00 | $urandom_range(0, 255);
					1: centre = 32'h80000000 | $urandom_range(0, 255);
					2: centre = $urandom_range(0, 511) - 256;
					default: centre = $urandom();
				endcase
				case ($urandom_range(0, 3))
					0: spread = 15;
					1: spread = 63;
					2: spread = WINDOW_BITS - 1;
					default: spread = WINDOW_BITS + 44;
				endcase
				phase_len = $urandom_range(20, 80);
				for (k = 0; k < phase_len && requests_sent < target; k++) begin
					roll = $urandom_range(0, 99);
					if (roll < 45) begin
						value = centre + $urandom_range(0, spread);
						send_request(MODE_ADD, value);
						added_values.push_back(value);
					end else if (roll < 90) begin
						if (added_values.size() != 0 && $urandom_range(0, 3) != 0)
							value = added_value_pick();
						else
							value = centre + $urandom_range(0, spread) - 8;
						send_request(roll < 70 ? MODE_REMOVE : MODE_SEARCH, value);
					end else if (roll < 95) begin
						send_request(MODE_SPARE, $urandom());
					end else begin
						send_request(2'($urandom_range(0, 2)), $urandom());
					end
				end
			end

			// Often remove the values added in this phase again, in random order.
			if ($urandom_range(0, 1) == 0) begin
				while (added_values.size() != 0 && requests_sent < target) begin
					idx = $urandom_range(0, added_values.size() - 1);
					send_request(MODE_REMOVE, added_values[idx]);
					added_values.delete(idx);
				end
			end
		end

		// Wait for the last results, then allow any stray result time to show.
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Ends the run if neither a request nor a result moves for too long.
	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
